// ===== src/dtq_pkg.sv =====
package dtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DELAY_W     = 32;
    localparam int OWNER_W     = 16;
    localparam int STATUS_W    = 2;

    // depth of the command and result queues
    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        OP_INSERT,
        OP_TICK
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EXPIRED  = 2'd2,
        STAT_NONE     = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [DELAY_W-1:0] delay;
        logic               kind;
        logic [OWNER_W-1:0] owner;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic               kind;
        logic [OWNER_W-1:0] owner;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_WALK,
        BS_SHIFT,
        BS_TICK,
        BS_POP,
        BS_REPLY
    } t_bstate;

endpackage

// ===== src/dtq_front.sv =====
// Input side: decodes each word into a command and queues it for the engine.
module dtq_front import dtq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_mode,
    input  logic [DELAY_W-1:0] i_delay,
    input  logic               i_kind,
    input  logic [OWNER_W-1:0] i_owner,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_take
);

    t_cmd              r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr, n_wr;
    logic [FPTR_W-1:0] r_rd, n_rd;
    logic [FCNT_W-1:0] r_cnt, n_cnt;
    logic              wr_en, rd_en;
    t_cmd              dec;

    assign o_full      = (r_cnt == FCNT_W'(FIFO_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_take && o_cmd_valid;

    always_comb begin
        dec.op    = i_mode ? OP_TICK : OP_INSERT;
        dec.delay = i_delay;
        dec.kind  = i_kind;
        dec.owner = i_owner;
    end

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (wr_en) begin
            n_wr = (r_wr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= dec;
        end
    end

endmodule

// ===== src/dtq_back.sv =====
// Timer engine: delta list in a shifting register file, walked one entry per cycle.
module dtq_back import dtq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_take,
    output logic    o_res_push,
    output t_result o_res,
    input  logic    i_res_room
);

    t_bstate            r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    t_cmd               r_cmd, n_cmd;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [DELAY_W:0]   r_total, n_total;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [DELAY_W-1:0] r_new_delta, n_new_delta;
    logic [DELAY_W-1:0] r_adj_delta, n_adj_delta;
    logic               r_adj, n_adj;
    t_status            r_status, n_status;

    logic [DELAY_W-1:0] r_delta [QUEUE_DEPTH];
    logic [DELAY_W-1:0] n_delta [QUEUE_DEPTH];
    logic               r_kind  [QUEUE_DEPTH];
    logic               n_kind  [QUEUE_DEPTH];
    logic [OWNER_W-1:0] r_owner [QUEUE_DEPTH];
    logic [OWNER_W-1:0] n_owner [QUEUE_DEPTH];

    logic [DELAY_W-1:0] walk_delta;
    logic [DELAY_W:0]   sum;
    logic               found;
    logic               at_end;
    logic [DELAY_W-1:0] head_dec;
    logic               pop_last;

    assign walk_delta = r_delta[r_idx[IDX_W-1:0]];
    assign sum        = r_total + {1'b0, walk_delta};
    assign found      = (sum >= {1'b0, r_cmd.delay});
    assign at_end     = (r_idx == r_count);
    assign head_dec   = (r_delta[0] == '0) ? '0 : r_delta[0] - 1'b1;
    // next head expires too only if it exists and already holds zero
    assign pop_last   = (r_count == CNT_W'(1)) || (r_delta[1] != '0);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_total     = r_total;
        n_pos       = r_pos;
        n_new_delta = r_new_delta;
        n_adj_delta = r_adj_delta;
        n_adj       = r_adj;
        n_status    = r_status;
        n_delta     = r_delta;
        n_kind      = r_kind;
        n_owner     = r_owner;

        o_cmd_take   = 1'b0;
        o_res_push   = 1'b0;
        o_res.status = STAT_NONE;
        o_res.kind   = 1'b0;
        o_res.owner  = '0;
        o_res.last   = 1'b1;

        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_cmd      = i_cmd;
                    if (i_cmd.op == OP_TICK) begin
                        n_state = BS_TICK;
                    end else if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                        n_status = STAT_FULL;
                        n_state  = BS_REPLY;
                    end else begin
                        n_idx   = '0;
                        n_total = '0;
                        n_state = BS_WALK;
                    end
                end
            end
            BS_WALK: begin
                if (at_end || found) begin
                    n_pos       = r_idx[IDX_W-1:0];
                    n_new_delta = r_cmd.delay - r_total[DELAY_W-1:0];
                    n_adj       = !at_end;
                    n_adj_delta = sum[DELAY_W-1:0] - r_cmd.delay;
                    n_state     = BS_SHIFT;
                end else begin
                    n_total = sum;
                    n_idx   = r_idx + 1'b1;
                end
            end
            BS_SHIFT: begin
                if (i_res_room) begin
                    o_res_push   = 1'b1;
                    o_res.status = STAT_INSERTED;
                    for (int j = 1; j < QUEUE_DEPTH; j++) begin
                        if (IDX_W'(j) > r_pos) begin
                            if (r_adj && (IDX_W'(j - 1) == r_pos)) begin
                                n_delta[j] = r_adj_delta;
                            end else begin
                                n_delta[j] = r_delta[j - 1];
                            end
                            n_kind[j]  = r_kind[j - 1];
                            n_owner[j] = r_owner[j - 1];
                        end
                    end
                    n_delta[r_pos] = r_new_delta;
                    n_kind[r_pos]  = r_cmd.kind;
                    n_owner[r_pos] = r_cmd.owner;
                    n_count        = r_count + 1'b1;
                    n_state        = BS_IDLE;
                end
            end
            BS_TICK: begin
                if (r_count == '0) begin
                    n_status = STAT_NONE;
                    n_state  = BS_REPLY;
                end else begin
                    n_delta[0] = head_dec;
                    if (head_dec == '0) begin
                        n_state = BS_POP;
                    end else begin
                        n_status = STAT_NONE;
                        n_state  = BS_REPLY;
                    end
                end
            end
            BS_POP: begin
                if (i_res_room) begin
                    o_res_push   = 1'b1;
                    o_res.status = STAT_EXPIRED;
                    o_res.kind   = r_kind[0];
                    o_res.owner  = r_owner[0];
                    o_res.last   = pop_last;
                    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                        n_delta[j] = r_delta[j + 1];
                        n_kind[j]  = r_kind[j + 1];
                        n_owner[j] = r_owner[j + 1];
                    end
                    n_count = r_count - 1'b1;
                    if (pop_last) begin
                        n_state = BS_IDLE;
                    end
                end
            end
            BS_REPLY: begin
                if (i_res_room) begin
                    o_res_push   = 1'b1;
                    o_res.status = r_status;
                    n_state      = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_total     <= n_total;
        r_pos       <= n_pos;
        r_new_delta <= n_new_delta;
        r_adj_delta <= n_adj_delta;
        r_adj       <= n_adj;
        r_status    <= n_status;
        r_delta     <= n_delta;
        r_kind      <= n_kind;
        r_owner     <= n_owner;
    end

endmodule

// ===== src/dtq_res_fifo.sv =====
// Result queue between the engine and the output port.
module dtq_res_fifo import dtq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_room,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_res
);

    t_result           r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr, n_wr;
    logic [FPTR_W-1:0] r_rd, n_rd;
    logic [FCNT_W-1:0] r_cnt, n_cnt;
    logic              wr_en, rd_en;

    assign o_room  = (r_cnt != FCNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rd];
    assign wr_en   = i_push && o_room;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (wr_en) begin
            n_wr = (r_wr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

// ===== src/delta_timer_queue.sv =====
// Delta-list timer queue. Each pushed word is an insert (mode 0: delay, kind,
// owner) or a tick (mode 1). Up to QUEUE_DEPTH timers are kept sorted, each
// storing the ticks left after the one ahead of it. An insert yields one word
// (inserted, or full if the list already holds QUEUE_DEPTH timers); a tick
// yields one expired word per timer that reaches zero, in expiry order, or a
// single nothing-expired word, with last set on the final word of each input.
// Engine steps: an insert walks the list with one adder-and-compare step per
// entry passed, then one step to stop and a shift/write step that waits for
// result room; a full reject goes straight to its reply. A tick decrements
// the head, then pops each timer that reaches zero in turn, or replies that
// nothing expired. The serial walk over the register file sets the pace. A
// two-word command queue in front and a two-word result queue behind let
// input and output stall independently.
// Reset is synchronous, active low; the list starts empty.
module delta_timer_queue import dtq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input queue side
    input  logic                push,
    output logic                full,
    input  logic                i_mode,
    input  logic [DELAY_W-1:0]  i_delay,
    input  logic                i_kind,
    input  logic [OWNER_W-1:0]  i_owner,
    // result queue side
    output logic                empty,
    input  logic                pop,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_expired_kind,
    output logic [OWNER_W-1:0]  o_expired_owner,
    output logic                o_last
);

    // front -> engine command word
    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_take;

    // engine -> result queue
    logic    res_push;
    t_result res_in;
    logic    res_room;
    t_result res_out;

    dtq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_delay     (i_delay),
        .i_kind      (i_kind),
        .i_owner     (i_owner),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    dtq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_room  (res_room)
    );

    dtq_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_room  (res_room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res_out)
    );

    // unpack the head result word onto the output fields
    assign o_status        = res_out.status;
    assign o_expired_kind  = res_out.kind;
    assign o_expired_owner = res_out.owner;
    assign o_last          = res_out.last;

endmodule
